[sv/adqd_pkg.sv]
// Shared types, field widths, reset values and helpers for the analog
// quadrature distance decoder. No dependencies.
`timescale 1ns / 1ps

package adqd_pkg;

  localparam int MAX_FRAME_SAMPLES_DEF = 32;
  localparam int SAMPLE_BITS_DEF       = 12;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 12;
  localparam int STEP_W   = 20;
  localparam int DIST_W   = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CHAN_W-1:0] CHAN_A_RST    = CHAN_W'(5);
  localparam logic [THR_W-1:0]  LOW_THR_RST   = THR_W'(600);
  localparam logic [THR_W-1:0]  HIGH_THR_RST  = THR_W'(1000);
  localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(7854);

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_PRESET = 1'b1;

  localparam logic DIR_ADD = 1'b0;
  localparam logic DIR_SUB = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAN_A   = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_HIGH_THR = 2'd2,
    REG_STEP     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_STEP
  } state_t;

  function automatic logic [1:0] gray_of(input logic [1:0] idx);
    return {idx[1], idx[1] ^ idx[0]};
  endfunction

endpackage

[sv/adqd_if.sv]
// Handshake channel interfaces for the decoder: input word, result word and
// configuration write. Depends on adqd_pkg.
`timescale 1ns / 1ps

interface adqd_in_if import adqd_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [CHAN_W-1:0]        channel;
  logic [SAMPLE_W-1:0]      sample;
  logic                     frame_end;
  logic signed [DIST_W-1:0] preset_value;

  modport source (output valid, func, channel, sample, frame_end, preset_value,
                  input ready);
  modport sink (input valid, func, channel, sample, frame_end, preset_value,
                output ready);
endinterface

interface adqd_out_if import adqd_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;
  logic                     direction;

  modport source (output valid, distance, direction, input ready);
  modport sink (input valid, distance, direction, output ready);
endinterface

interface adqd_cfg_if import adqd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/adqd_serial_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on no other file.
`timescale 1ns / 1ps

module adqd_serial_div #(
  parameter int DW = 18,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   sh_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;

  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, sh_r[DW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_nxt  = ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= {sh_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

[sv/analog_quadrature_distance_decoder.sv]
// Top level of the analog quadrature distance decoder.
// Depends on adqd_pkg, adqd_if and adqd_serial_div.
`timescale 1ns / 1ps

// Usage:
// ADC words arrive on in_chan. A sample word on the sensor A channel adds to
// sum A, any other channel adds to sum B; a preset word loads the distance.
// Ordinary sample and preset words are accepted in the idle state and in_chan.ready
// stays high for them. A sample word with frame_end set starts the frame
// close: both averages pass in turn through one serial divider, one quotient
// bit per cycle, then the phase index moves; in_chan.ready is low during
// the close.
// A wrap of the phase index emits one word on out_chan with the saturated
// distance and the direction. The result is held in an output register, so
// new input words are taken while it waits; only a second result waiting on
// a stalled receiver holds the close in its last cycle.
// cfg_chan is always ready and writes one register per word.
// Synchronous reset restores the register defaults and clears the sums,
// counts, sensor levels, phase index and distance.

module analog_quadrature_distance_decoder import adqd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  adqd_in_if.sink    in_chan,
  adqd_out_if.source out_chan,
  adqd_cfg_if.sink   cfg_chan
);

  localparam int CW   = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SUMW = SW + CW;
  localparam int CMPW = (SUMW > THR_W) ? SUMW : THR_W;

  logic [CHAN_W-1:0] chan_a_r;
  logic [THR_W-1:0]  low_thr_r;
  logic [THR_W-1:0]  high_thr_r;
  logic [STEP_W-1:0] step_r;

  state_t state_r, state_nxt;
  logic [SUMW-1:0] sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic [CW-1:0]   count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic            level_a_r, level_a_nxt, level_b_r, level_b_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic            out_dir_r;

  logic            in_acc;
  logic            is_a;
  logic [SUMW-1:0] smp_ext;
  logic            div_start;
  logic [SUMW-1:0] div_dividend;
  logic [CW-1:0]   div_divisor;
  logic            div_done;
  logic [SUMW-1:0] div_q;
  logic [CMPW-1:0] q_ext;
  logic            below_low;
  logic            above_high;
  logic [1:0]      phase;
  logic            fwd;
  logic            bwd;
  logic            wrap;
  logic            dir_sub;
  logic [DIST_W:0] acc_ext;
  logic [DIST_W:0] step_ext;
  logic [DIST_W:0] dsum;
  logic [DIST_W-1:0] dist_step;
  logic            emit;

  adqd_serial_div #(
    .DW(SUMW),
    .VW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_comb begin
    is_a       = (in_chan.channel == chan_a_r);
    smp_ext    = SUMW'(in_chan.sample[SW-1:0]);
    q_ext      = CMPW'(div_q);
    below_low  = q_ext < CMPW'(low_thr_r);
    above_high = q_ext > CMPW'(high_thr_r);

    phase   = {level_b_r, level_a_r};
    fwd     = (phase == gray_of(idx_r + 2'd1));
    bwd     = !fwd && (phase == gray_of(idx_r - 2'd1));
    wrap    = (fwd && (idx_r == 2'd3)) || (bwd && (idx_r == 2'd0));
    dir_sub = fwd;

    acc_ext  = {dist_r[DIST_W-1], dist_r};
    step_ext = (DIST_W + 1)'(step_r);
    dsum     = dir_sub ? (acc_ext - step_ext) : (acc_ext + step_ext);
    if (dsum[DIST_W] != dsum[DIST_W-1]) begin
      dist_step = dir_sub ? DIST_MIN : DIST_MAX;
    end else begin
      dist_step = dsum[DIST_W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    count_a_nxt  = count_a_r;
    count_b_nxt  = count_b_r;
    level_a_nxt  = level_a_r;
    level_b_nxt  = level_b_r;
    idx_nxt      = idx_r;
    dist_nxt     = dist_r;
    div_start    = 1'b0;
    div_dividend = sum_b_r;
    div_divisor  = count_b_r;
    emit         = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == FUNC_PRESET) begin
            dist_nxt = in_chan.preset_value;
          end else begin
            if (is_a) begin
              if (count_a_r < CW'(MAX_FRAME_SAMPLES)) begin
                sum_a_nxt   = sum_a_r + smp_ext;
                count_a_nxt = count_a_r + CW'(1);
              end
            end else begin
              if (count_b_r < CW'(MAX_FRAME_SAMPLES)) begin
                sum_b_nxt   = sum_b_r + smp_ext;
                count_b_nxt = count_b_r + CW'(1);
              end
            end
            if (in_chan.frame_end) begin
              div_start    = 1'b1;
              div_dividend = sum_a_nxt;
              div_divisor  = count_a_nxt;
              state_nxt    = ST_DIV_A;
            end
          end
        end
      end
      ST_DIV_A: begin
        if (div_done) begin
          if (count_a_r != '0) begin
            level_a_nxt = level_a_r ? !below_low : above_high;
          end
          div_start = 1'b1;
          state_nxt = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_done) begin
          if (count_b_r != '0) begin
            level_b_nxt = level_b_r ? !below_low : above_high;
          end
          sum_a_nxt   = '0;
          sum_b_nxt   = '0;
          count_a_nxt = '0;
          count_b_nxt = '0;
          state_nxt   = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!(wrap && out_valid_r && !out_chan.ready)) begin
          if (fwd) begin
            idx_nxt = idx_r + 2'd1;
          end else if (bwd) begin
            idx_nxt = idx_r - 2'd1;
          end
          if (wrap) begin
            dist_nxt      = dist_step;
            emit          = 1'b1;
            out_valid_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_a_r    <= CHAN_A_RST;
      low_thr_r   <= LOW_THR_RST;
      high_thr_r  <= HIGH_THR_RST;
      step_r      <= STEP_RST;
      state_r     <= ST_IDLE;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      count_a_r   <= '0;
      count_b_r   <= '0;
      level_a_r   <= 1'b0;
      level_b_r   <= 1'b0;
      idx_r       <= 2'd0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_reg_t'(cfg_chan.index))
          REG_CHAN_A:   chan_a_r   <= cfg_chan.data[CHAN_W-1:0];
          REG_LOW_THR:  low_thr_r  <= cfg_chan.data[THR_W-1:0];
          REG_HIGH_THR: high_thr_r <= cfg_chan.data[THR_W-1:0];
          REG_STEP:     step_r     <= cfg_chan.data[STEP_W-1:0];
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      level_a_r   <= level_a_nxt;
      level_b_r   <= level_b_nxt;
      idx_r       <= idx_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_dist_r <= dist_step;
      out_dir_r  <= dir_sub ? DIR_SUB : DIR_ADD;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.distance  = out_dist_r;
  assign out_chan.direction = out_dir_r;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_A || state_r == ST_DIV_B))
    else $error("divider finished outside a frame close");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_chan.func == FUNC_SAMPLE) && in_chan.frame_end)
      |=> (state_r == ST_DIV_A))
    else $error("frame end word did not start the close");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(MAX_FRAME_SAMPLES)) && (count_b_r <= CW'(MAX_FRAME_SAMPLES)))
    else $error("sample count above the frame limit");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted result not shown on the output");
`endif

endmodule
